// ----- sv/rcp_pkg.sv -----
// ----------------------------------------------------------------------------
// RC pulse conditioner package
// Shared types and fixed constants for the pulse conditioner.
// ----------------------------------------------------------------------------
package rcp_pkg;

  // Deflection is reported in whole percent.
  localparam int unsigned PCT_SCALE = 100;
  localparam int unsigned PCT_W     = 7;
  // A quotient below 100 needs seven bits, so the divider runs seven steps.
  localparam int unsigned DIV_STEPS = 7;
  localparam int unsigned DIV_CNT_W = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Register reset values.
  localparam int unsigned RST_NEUTRAL_HIGH = 1550;
  localparam int unsigned RST_NEUTRAL_LOW  = 1450;
  localparam int unsigned RST_CLAMP_HIGH   = 2000;
  localparam int unsigned RST_CLAMP_LOW    = 1000;
  localparam int unsigned RST_LOST_HIGH    = 100;
  localparam int unsigned RST_STEP_LIMIT   = 50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEUTRAL_HIGH = 3'd0,
    REG_NEUTRAL_LOW  = 3'd1,
    REG_CLAMP_HIGH   = 3'd2,
    REG_CLAMP_LOW    = 3'd3,
    REG_LOST_HIGH    = 3'd4,
    REG_LOST_LOW     = 3'd5,
    REG_SLEW_ENABLE  = 3'd6,
    REG_STEP_LIMIT   = 3'd7
  } rcp_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIM_HI,
    ST_CMP_HI,
    ST_LIM_LO,
    ST_CMP_LO,
    ST_CLAMP_HI,
    ST_CLAMP_LO,
    ST_FWD,
    ST_BWD,
    ST_LOST_LO,
    ST_LOST_HI,
    ST_DEN,
    ST_CAP,
    ST_DIV,
    ST_DONE
  } rcp_state_t;

endpackage

// ----- sv/rcp_in_if.sv -----
// ----------------------------------------------------------------------------
// RC pulse input channel
// Valid/ready channel carrying one measured pulse width per transfer.
// ----------------------------------------------------------------------------
interface rcp_in_if #(
  parameter int WIDTH_BITS = 15
);
  logic                  valid;
  logic                  ready;
  logic [WIDTH_BITS-1:0] pulse_width;

  modport source (output valid, output pulse_width, input ready);
  modport sink   (input valid, input pulse_width, output ready);
endinterface

// ----- sv/rcp_out_if.sv -----
// ----------------------------------------------------------------------------
// RC pulse result channel
// Valid/ready channel carrying the conditioned position and its flags.
// ----------------------------------------------------------------------------
interface rcp_out_if #(
  parameter int WIDTH_BITS = 15
);
  logic                             valid;
  logic                             ready;
  logic [WIDTH_BITS-1:0]            position;
  logic                             forward;
  logic                             backward;
  logic                             link_lost;
  logic [rcp_pkg::PCT_W-1:0]        drive_percent;

  modport source (output valid, output position, output forward, output backward,
                  output link_lost, output drive_percent, input ready);
  modport sink   (input valid, input position, input forward, input backward,
                  input link_lost, input drive_percent, output ready);
endinterface

// ----- sv/rc_pulse_conditioner.sv -----
// ----------------------------------------------------------------------------
// RC pulse conditioner
// One pulse width at a time: slew limiting adds LIM_HI, CMP_HI, LIM_LO and
// CMP_LO, a deflected position CAP and, below full scale, the divider steps.
// Every step shares the single add/subtract unit; the result register frees
// the sequencer early, and it takes the next input once back in idle.
// Reset (synchronous, active low) restores the register defaults and clears
// the stored previous position to zero.
// ----------------------------------------------------------------------------
module rc_pulse_conditioner #(
  parameter int WIDTH_BITS = 15
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rcp_in_if.sink                          in_ch,
  rcp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [rcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [WIDTH_BITS:0]             cfg_data
);

  // Unit width covers num * 100 and prev + step with a sign bit to spare.
  localparam int UW = WIDTH_BITS + 8;

  typedef logic signed [UW-1:0] word_t;

  // Configuration registers.
  logic [WIDTH_BITS-1:0]        neutral_high_r, neutral_low_r;
  logic [WIDTH_BITS-1:0]        clamp_high_r, clamp_low_r;
  logic [WIDTH_BITS-1:0]        lost_high_r, step_limit_r;
  logic signed [WIDTH_BITS:0]   lost_low_r;
  logic                         slew_enable_r;

  // Sequencer and datapath registers.
  rcp_pkg::rcp_state_t          state_r, state_nxt;
  logic [WIDTH_BITS-1:0]        prev_r, prev_nxt;
  logic [WIDTH_BITS-1:0]        raw_r, raw_nxt;
  word_t                        pos_r, pos_nxt;
  word_t                        lim_r, lim_nxt;
  word_t                        num_r, num_nxt;
  word_t                        den_r, den_nxt;
  word_t                        rem_r, rem_nxt;
  word_t                        dsh_r, dsh_nxt;
  logic [rcp_pkg::PCT_W-1:0]    q_r, q_nxt;
  logic [rcp_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                         fwd_r, fwd_nxt;
  logic                         bwd_r, bwd_nxt;
  logic                         lost_r, lost_nxt;

  // Result register.
  logic                         out_valid_r, out_valid_nxt;
  logic [WIDTH_BITS-1:0]        out_pos_r, out_pos_nxt;
  logic                         out_fwd_r, out_fwd_nxt;
  logic                         out_bwd_r, out_bwd_nxt;
  logic                         out_lost_r, out_lost_nxt;
  logic [rcp_pkg::PCT_W-1:0]    out_pct_r, out_pct_nxt;

  // Shared add/subtract unit.
  word_t                        op_a, op_b, sum;
  logic                         op_sub, sum_neg, sum_zero;

  logic                         in_xfer, out_xfer, out_free, den_bad;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid_r && out_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign sum      = op_a + (op_sub ? ~op_b : op_b) + UW'(op_sub);
  assign sum_neg  = sum[UW-1];
  assign sum_zero = (sum == '0);
  assign den_bad  = den_r[UW-1] || (den_r == '0);

  assign in_ch.ready          = (state_r == rcp_pkg::ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.position      = out_pos_r;
  assign out_ch.forward       = out_fwd_r;
  assign out_ch.backward      = out_bwd_r;
  assign out_ch.link_lost     = out_lost_r;
  assign out_ch.drive_percent = out_pct_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neutral_high_r <= WIDTH_BITS'(rcp_pkg::RST_NEUTRAL_HIGH);
      neutral_low_r  <= WIDTH_BITS'(rcp_pkg::RST_NEUTRAL_LOW);
      clamp_high_r   <= WIDTH_BITS'(rcp_pkg::RST_CLAMP_HIGH);
      clamp_low_r    <= WIDTH_BITS'(rcp_pkg::RST_CLAMP_LOW);
      lost_high_r    <= WIDTH_BITS'(rcp_pkg::RST_LOST_HIGH);
      lost_low_r     <= '1;
      slew_enable_r  <= 1'b0;
      step_limit_r   <= WIDTH_BITS'(rcp_pkg::RST_STEP_LIMIT);
    end else if (cfg_we) begin
      unique case (rcp_pkg::rcp_reg_t'(cfg_index))
        rcp_pkg::REG_NEUTRAL_HIGH: neutral_high_r <= cfg_data[WIDTH_BITS-1:0];
        rcp_pkg::REG_NEUTRAL_LOW:  neutral_low_r  <= cfg_data[WIDTH_BITS-1:0];
        rcp_pkg::REG_CLAMP_HIGH:   clamp_high_r   <= cfg_data[WIDTH_BITS-1:0];
        rcp_pkg::REG_CLAMP_LOW:    clamp_low_r    <= cfg_data[WIDTH_BITS-1:0];
        rcp_pkg::REG_LOST_HIGH:    lost_high_r    <= cfg_data[WIDTH_BITS-1:0];
        rcp_pkg::REG_LOST_LOW:     lost_low_r     <= cfg_data;
        rcp_pkg::REG_SLEW_ENABLE:  slew_enable_r  <= cfg_data[0];
        rcp_pkg::REG_STEP_LIMIT:   step_limit_r   <= cfg_data[WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rcp_pkg::ST_IDLE:
        if (in_xfer) begin
          state_nxt = slew_enable_r ? rcp_pkg::ST_LIM_HI : rcp_pkg::ST_CLAMP_HI;
        end
      rcp_pkg::ST_LIM_HI:   state_nxt = rcp_pkg::ST_CMP_HI;
      rcp_pkg::ST_CMP_HI:   state_nxt = rcp_pkg::ST_LIM_LO;
      rcp_pkg::ST_LIM_LO:   state_nxt = rcp_pkg::ST_CMP_LO;
      rcp_pkg::ST_CMP_LO:   state_nxt = rcp_pkg::ST_CLAMP_HI;
      rcp_pkg::ST_CLAMP_HI: state_nxt = rcp_pkg::ST_CLAMP_LO;
      rcp_pkg::ST_CLAMP_LO: state_nxt = rcp_pkg::ST_FWD;
      rcp_pkg::ST_FWD:      state_nxt = rcp_pkg::ST_BWD;
      rcp_pkg::ST_BWD:      state_nxt = rcp_pkg::ST_LOST_LO;
      rcp_pkg::ST_LOST_LO:  state_nxt = rcp_pkg::ST_LOST_HI;
      rcp_pkg::ST_LOST_HI:  state_nxt = rcp_pkg::ST_DEN;
      rcp_pkg::ST_DEN:
        state_nxt = (fwd_r || bwd_r) ? rcp_pkg::ST_CAP : rcp_pkg::ST_DONE;
      rcp_pkg::ST_CAP:
        state_nxt = (den_bad || !sum_neg) ? rcp_pkg::ST_DONE : rcp_pkg::ST_DIV;
      rcp_pkg::ST_DIV:
        if (cnt_r == '0) begin
          state_nxt = rcp_pkg::ST_DONE;
        end
      rcp_pkg::ST_DONE:
        if (out_free) begin
          state_nxt = rcp_pkg::ST_IDLE;
        end
      default: state_nxt = rcp_pkg::ST_IDLE;
    endcase
  end

  // Operand selection and datapath updates.
  always_comb begin
    op_a          = '0;
    op_b          = '0;
    op_sub        = 1'b1;
    prev_nxt      = prev_r;
    raw_nxt       = raw_r;
    pos_nxt       = pos_r;
    lim_nxt       = lim_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    fwd_nxt       = fwd_r;
    bwd_nxt       = bwd_r;
    lost_nxt      = lost_r;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_fwd_nxt   = out_fwd_r;
    out_bwd_nxt   = out_bwd_r;
    out_lost_nxt  = out_lost_r;
    out_pct_nxt   = out_pct_r;
    unique case (state_r)
      rcp_pkg::ST_IDLE:
        if (in_xfer) begin
          raw_nxt = in_ch.pulse_width;
          pos_nxt = UW'(in_ch.pulse_width);
        end
      rcp_pkg::ST_LIM_HI: begin
        op_a    = UW'(prev_r);
        op_b    = UW'(step_limit_r);
        op_sub  = 1'b0;
        lim_nxt = sum;
      end
      rcp_pkg::ST_CMP_HI: begin
        op_a = lim_r;
        op_b = pos_r;
        if (sum_neg) begin
          pos_nxt = lim_r;
        end
      end
      rcp_pkg::ST_LIM_LO: begin
        op_a    = UW'(prev_r);
        op_b    = UW'(step_limit_r);
        lim_nxt = sum;
      end
      rcp_pkg::ST_CMP_LO: begin
        op_a = pos_r;
        op_b = lim_r;
        if (sum_neg) begin
          pos_nxt = lim_r;
        end
      end
      rcp_pkg::ST_CLAMP_HI: begin
        op_a = UW'(clamp_high_r);
        op_b = pos_r;
        if (sum_neg) begin
          pos_nxt = UW'(clamp_high_r);
        end
      end
      rcp_pkg::ST_CLAMP_LO: begin
        // After the lower clamp the position always fits the field.
        op_a = pos_r;
        op_b = UW'(clamp_low_r);
        if (sum_neg) begin
          pos_nxt  = UW'(clamp_low_r);
          prev_nxt = clamp_low_r;
        end else begin
          prev_nxt = pos_r[WIDTH_BITS-1:0];
        end
      end
      rcp_pkg::ST_FWD: begin
        op_a    = pos_r;
        op_b    = UW'(neutral_high_r);
        fwd_nxt = !sum_neg && !sum_zero;
        num_nxt = sum;
      end
      rcp_pkg::ST_BWD: begin
        op_a    = UW'(neutral_low_r);
        op_b    = pos_r;
        bwd_nxt = !sum_neg && !sum_zero;
        // The forward side wins when the neutral band is inverted.
        if (!fwd_r) begin
          num_nxt = sum;
        end
      end
      rcp_pkg::ST_LOST_LO: begin
        op_a     = UW'(lost_low_r);
        op_b     = UW'(raw_r);
        lost_nxt = sum_neg;
      end
      rcp_pkg::ST_LOST_HI: begin
        op_a     = UW'(raw_r);
        op_b     = UW'(lost_high_r);
        lost_nxt = lost_r && sum_neg;
      end
      rcp_pkg::ST_DEN: begin
        if (fwd_r) begin
          op_a = UW'(clamp_high_r);
          op_b = UW'(neutral_high_r);
        end else begin
          op_a = UW'(neutral_low_r);
          op_b = UW'(clamp_low_r);
        end
        den_nxt = sum;
        q_nxt   = '0;
      end
      rcp_pkg::ST_CAP: begin
        // A numerator at or above the divisor, or a divisor not above zero, gives 100 percent.
        op_a = num_r;
        op_b = den_r;
        if (den_bad || !sum_neg) begin
          q_nxt = rcp_pkg::PCT_W'(rcp_pkg::PCT_SCALE);
        end else begin
          rem_nxt = (num_r <<< 6) + (num_r <<< 5) + (num_r <<< 2);
          dsh_nxt = den_r <<< (rcp_pkg::DIV_STEPS - 1);
          cnt_nxt = rcp_pkg::DIV_CNT_W'(rcp_pkg::DIV_STEPS - 1);
          q_nxt   = '0;
        end
      end
      rcp_pkg::ST_DIV: begin
        op_a = rem_r;
        op_b = dsh_r;
        if (!sum_neg) begin
          rem_nxt = sum;
        end
        q_nxt   = {q_r[rcp_pkg::PCT_W-2:0], !sum_neg};
        dsh_nxt = dsh_r >>> 1;
        cnt_nxt = cnt_r - 1'b1;
      end
      rcp_pkg::ST_DONE:
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r[WIDTH_BITS-1:0];
          out_fwd_nxt   = fwd_r;
          out_bwd_nxt   = bwd_r;
          out_lost_nxt  = lost_r;
          out_pct_nxt   = q_r;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rcp_pkg::ST_IDLE;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    pos_r      <= pos_nxt;
    lim_r      <= lim_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    dsh_r      <= dsh_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    fwd_r      <= fwd_nxt;
    bwd_r      <= bwd_nxt;
    lost_r     <= lost_nxt;
    out_pos_r  <= out_pos_nxt;
    out_fwd_r  <= out_fwd_nxt;
    out_bwd_r  <= out_bwd_nxt;
    out_lost_r <= out_lost_nxt;
    out_pct_r  <= out_pct_nxt;
  end

  // The percentage never exceeds full deflection.
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pct_r <= rcp_pkg::PCT_W'(rcp_pkg::PCT_SCALE)))
    else $error("drive percent above full scale");

  // A neutral position reports no deflection.
  a_neutral_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_fwd_r && !out_bwd_r) |-> (out_pct_r == '0))
    else $error("deflection reported for neutral position");

  // An accepted transfer always starts the sequencer.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != rcp_pkg::ST_IDLE))
    else $error("sequencer did not start after an input transfer");

  // The divider finishes after its last step.
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rcp_pkg::ST_DIV && cnt_r == '0) |=> (state_r == rcp_pkg::ST_DONE))
    else $error("divider overran its step count");

endmodule

// ----- dv/rcp_pulse_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse conditioner result checker
// Follows every input and result transfer and every register write. It
// predicts each conditioned position, its flags and its deflection, and
// compares them in order with what the block returns.
// ----------------------------------------------------------------------------
module rcp_pulse_checker #(
  parameter int WIDTH_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rcp_in_if                             in_ch,
  rcp_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [rcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_BITS:0]           cfg_data,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic [WIDTH_BITS-1:0]     position;
    logic                      forward;
    logic                      backward;
    logic                      link_lost;
    logic [rcp_pkg::PCT_W-1:0] drive_percent;
  } pulse_result_t;

  pulse_result_t expected_results[$];

  int neutral_hi;
  int neutral_lo;
  int clamp_hi;
  int clamp_lo;
  int lost_hi;
  int lost_lo;
  int step_max;
  int last_position;
  bit slew_on;
  int failures = 0;

  function automatic int deflection_pct(input int num, input int den);
    int q;
    if (den <= 0) return rcp_pkg::PCT_SCALE;
    if (num <= 0) return 0;
    q = (num * rcp_pkg::PCT_SCALE) / den;
    return (q > rcp_pkg::PCT_SCALE) ? rcp_pkg::PCT_SCALE : q;
  endfunction

  function automatic pulse_result_t condition_pulse(input logic [WIDTH_BITS-1:0] width);
    int raw;
    int pos;
    int pct;
    pulse_result_t r;
    raw = int'(width);
    pos = raw;
    if (slew_on) begin
      if (pos > last_position && pos - last_position > step_max)
        pos = last_position + step_max;
      if (pos < last_position && last_position - pos > step_max)
        pos = last_position - step_max;
    end
    // The upper limit goes first, so inverted limits settle on the lower one.
    if (pos > clamp_hi) pos = clamp_hi;
    if (pos < clamp_lo) pos = clamp_lo;
    r.position  = WIDTH_BITS'(pos);
    r.forward   = pos > neutral_hi;
    r.backward  = pos < neutral_lo;
    r.link_lost = (raw > lost_lo) && (raw < lost_hi);
    pct = 0;
    if (r.forward)
      pct = deflection_pct(pos - neutral_hi, clamp_hi - neutral_hi);
    else if (r.backward)
      pct = deflection_pct(neutral_lo - pos, neutral_lo - clamp_lo);
    r.drive_percent = rcp_pkg::PCT_W'(pct);
    return r;
  endfunction

  always @(posedge clk) begin
    pulse_result_t seen;
    pulse_result_t want;
    if (!rst_n) begin
      neutral_hi    = rcp_pkg::RST_NEUTRAL_HIGH;
      neutral_lo    = rcp_pkg::RST_NEUTRAL_LOW;
      clamp_hi      = rcp_pkg::RST_CLAMP_HIGH;
      clamp_lo      = rcp_pkg::RST_CLAMP_LOW;
      lost_hi       = rcp_pkg::RST_LOST_HIGH;
      lost_lo       = -1;
      slew_on       = 1'b0;
      step_max      = rcp_pkg::RST_STEP_LIMIT;
      last_position = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (rcp_pkg::rcp_reg_t'(cfg_index))
          rcp_pkg::REG_NEUTRAL_HIGH: neutral_hi = int'(cfg_data[WIDTH_BITS-1:0]);
          rcp_pkg::REG_NEUTRAL_LOW:  neutral_lo = int'(cfg_data[WIDTH_BITS-1:0]);
          rcp_pkg::REG_CLAMP_HIGH:   clamp_hi   = int'(cfg_data[WIDTH_BITS-1:0]);
          rcp_pkg::REG_CLAMP_LOW:    clamp_lo   = int'(cfg_data[WIDTH_BITS-1:0]);
          rcp_pkg::REG_LOST_HIGH:    lost_hi    = int'(cfg_data[WIDTH_BITS-1:0]);
          rcp_pkg::REG_LOST_LOW:     lost_lo    = int'($signed(cfg_data));
          rcp_pkg::REG_SLEW_ENABLE:  slew_on    = cfg_data[0];
          rcp_pkg::REG_STEP_LIMIT:   step_max   = int'(cfg_data[WIDTH_BITS-1:0]);
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        seen.position      = out_ch.position;
        seen.forward       = out_ch.forward;
        seen.backward      = out_ch.backward;
        seen.link_lost     = out_ch.link_lost;
        seen.drive_percent = out_ch.drive_percent;
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%t: result transfer with none expected: pos %0d fwd %0b",
                     $time, seen.position, seen.forward,
                     " bwd %0b lost %0b pct %0d",
                     seen.backward, seen.link_lost, seen.drive_percent);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            failures++;
            if (failures <= 10)
              $display("%t: result mismatch (expected/actual): pos %0d/%0d",
                       $time, want.position, seen.position,
                       " fwd %0b/%0b bwd %0b/%0b", want.forward, seen.forward,
                       want.backward, seen.backward,
                       " lost %0b/%0b pct %0d/%0d", want.link_lost, seen.link_lost,
                       want.drive_percent, seen.drive_percent);
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        want = condition_pulse(in_ch.pulse_width);
        last_position = int'(want.position);
        expected_results.push_back(want);
      end
    end
    fail_count <= failures;
    pending    <= expected_results.size();
  end

endmodule

// ----- dv/rc_pulse_conditioner_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse conditioner testbench
// Drives pulse widths and register settings into the conditioner with random
// gaps and stalls on both channels, and leaves prediction and comparison to
// the checker that sits beside the block. A directed run over the limits and
// corner settings is followed by randomised phases under varied settings.
// ----------------------------------------------------------------------------
module rc_pulse_conditioner_tb;

  localparam int WIDTH_BITS = 15;
  localparam int FIELD_MAX  = (1 << WIDTH_BITS) - 1;
  localparam int LONG_HOLD  = 300;
  localparam int PHASES     = 12;
  localparam int PHASE_ITEMS = 140;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [rcp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [WIDTH_BITS:0]           cfg_data;
  int                            fail_count;
  int                            pending;

  logic [WIDTH_BITS:0]   reg_value [8];
  bit                    steady_flow = 1'b0;
  bit                    hold_request = 1'b0;

  rcp_in_if  #(.WIDTH_BITS(WIDTH_BITS)) in_ch ();
  rcp_out_if #(.WIDTH_BITS(WIDTH_BITS)) out_ch ();

  rc_pulse_conditioner #(.WIDTH_BITS(WIDTH_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rcp_pulse_checker #(.WIDTH_BITS(WIDTH_BITS)) pulse_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("rc_pulse_conditioner regression: fail");
    $finish;
  end

  // Result side: a random stall before each transfer, or one long hold-off
  // when asked, during which the block has to back up onto its input.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = steady_flow ? 0 : $urandom_range(0, 4);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
          while (!out_ch.valid) @(posedge clk);
          repeat (stall - 1) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Valid is only lowered when a gap follows, so back-to-back transfers keep
  // it high without a second assignment in the same step.
  task automatic send_pulse(input logic [WIDTH_BITS-1:0] width);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pulse_width <= width;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic configure(input int nh, input int nl, input int ch, input int cl,
                           input int lh, input int ll, input int slew, input int step);
    reg_value[rcp_pkg::REG_NEUTRAL_HIGH] = (WIDTH_BITS + 1)'(nh);
    reg_value[rcp_pkg::REG_NEUTRAL_LOW]  = (WIDTH_BITS + 1)'(nl);
    reg_value[rcp_pkg::REG_CLAMP_HIGH]   = (WIDTH_BITS + 1)'(ch);
    reg_value[rcp_pkg::REG_CLAMP_LOW]    = (WIDTH_BITS + 1)'(cl);
    reg_value[rcp_pkg::REG_LOST_HIGH]    = (WIDTH_BITS + 1)'(lh);
    reg_value[rcp_pkg::REG_LOST_LOW]     = (WIDTH_BITS + 1)'(ll);
    reg_value[rcp_pkg::REG_SLEW_ENABLE]  = (WIDTH_BITS + 1)'(slew);
    reg_value[rcp_pkg::REG_STEP_LIMIT]   = (WIDTH_BITS + 1)'(step);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= rcp_pkg::rcp_reg_t'(i);
      cfg_data  <= reg_value[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int limit_or_any();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return FIELD_MAX;
      default: return $urandom_range(0, FIELD_MAX);
    endcase
  endfunction

  task automatic choose_settings(input int style);
    int ll;
    case (style)
      0: begin
        configure(1500 + $urandom_range(0, 200), 1300 + $urandom_range(0, 200),
                  1800 + $urandom_range(0, 400), 800 + $urandom_range(0, 400),
                  $urandom_range(0, 1000), int'($urandom_range(0, 201)) - 1,
                  $urandom_range(0, 1), $urandom_range(0, 300));
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       ll = -1;
          1:       ll = FIELD_MAX;
          2:       ll = -(FIELD_MAX + 1);
          default: ll = $urandom_range(0, 2 * FIELD_MAX + 1);
        endcase
        configure(limit_or_any(), limit_or_any(), limit_or_any(), limit_or_any(),
                  limit_or_any(), ll, $urandom_range(0, 1), limit_or_any());
      end
      default: begin
        configure($urandom_range(0, FIELD_MAX), $urandom_range(0, FIELD_MAX),
                  $urandom_range(0, FIELD_MAX), $urandom_range(0, FIELD_MAX),
                  $urandom_range(0, FIELD_MAX), $urandom_range(0, 2 * FIELD_MAX + 1),
                  $urandom_range(0, 1), $urandom_range(0, FIELD_MAX));
      end
    endcase
  endtask

  // Most widths land around the clamp range so that the flags, the slew
  // limit and the deflection all move; the rest go near zero, to the field's ends or anywhere in it.
  function automatic int pick_width();
    int cl;
    int ch;
    int lo;
    int hi;
    int roll;
    cl = int'(reg_value[rcp_pkg::REG_CLAMP_LOW][WIDTH_BITS-1:0]);
    ch = int'(reg_value[rcp_pkg::REG_CLAMP_HIGH][WIDTH_BITS-1:0]);
    lo = ((cl < ch) ? cl : ch) - 300;
    hi = ((cl < ch) ? ch : cl) + 300;
    if (lo < 0) lo = 0;
    if (hi > FIELD_MAX) hi = FIELD_MAX;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(lo, hi);
    if (roll < 80) return $urandom_range(0, 150);
    if (roll < 85) return $urandom_range(0, 1) ? FIELD_MAX : 0;
    return $urandom_range(0, FIELD_MAX);
  endfunction

  initial begin : stimulus
    int reset_pulses [14] = '{0, 1, 99, 100, 32767, 999, 1000, 1449, 1450, 1500,
                              1550, 1551, 2000, 2001};
    int band_pulses [5]   = '{1500, 1000, 2000, 0, 32767};
    int clamp_pulses [4]  = '{0, 32767, 1600, 20000};
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= rcp_pkg::REG_NEUTRAL_HIGH;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.pulse_width <= '0;
    reg_value[rcp_pkg::REG_CLAMP_HIGH] = (WIDTH_BITS + 1)'(rcp_pkg::RST_CLAMP_HIGH);
    reg_value[rcp_pkg::REG_CLAMP_LOW]  = (WIDTH_BITS + 1)'(rcp_pkg::RST_CLAMP_LOW);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults straight after reset: edges of the lost window,
    // the clamp and the neutral band.
    foreach (reset_pulses[i]) send_pulse(WIDTH_BITS'(reset_pulses[i]));

    // Inverted neutral band with full-range slew and the widest lost window.
    wait_all_results();
    configure(1400, 1600, 2000, 1000, FIELD_MAX, -(FIELD_MAX + 1), 1, FIELD_MAX);
    foreach (band_pulses[i]) send_pulse(WIDTH_BITS'(band_pulses[i]));

    // Inverted clamp limits, an empty forward range, a frozen slew step and
    // a lost window that can never match.
    wait_all_results();
    configure(1500, 0, 1500, 1800, 0, FIELD_MAX, 1, 0);
    foreach (clamp_pulses[i]) send_pulse(WIDTH_BITS'(clamp_pulses[i]));

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_all_results();
      choose_settings(phase % 3);
      steady_flow = (phase == 1) || ($urandom_range(0, 3) == 0);
      if (phase == 3) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 6 && n == PHASE_ITEMS / 2) wait_all_results();
        send_pulse(WIDTH_BITS'(pick_width()));
      end
    end

    wait_all_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("rc_pulse_conditioner regression: pass");
    end else begin
      $display("rc_pulse_conditioner regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/rcp_pkg.sv
sv/rcp_in_if.sv
sv/rcp_out_if.sv
sv/rc_pulse_conditioner.sv
dv/rcp_pulse_checker.sv
dv/rc_pulse_conditioner_tb.sv
